### hw/rtl/qfo_pkg.sv
// qfo_pkg: shared types, constants and state codes for the quadratic fade-out block
// no dependencies; imported by every module of the block

package qfo_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned GAIN_W     = 17;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // gain of one, as 1.16 fixed point
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

    // quotient bits produced by the divider, one per cycle
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // register index, taken from paddr bit 2
    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_FADE  = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       restart;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [GAIN_W-1:0]          gain_applied;
        logic                       song_end;
    } result_t;

    // work handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [COUNT_W-1:0]         frames;
        logic                       fade;
        logic                       song_end;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQUARE,
        BK_SCALE,
        BK_OUT
    } back_state_t;

endpackage

### hw/rtl/quadratic_fade_out_top.sv
// quadratic_fade_out_top: top level of the closing-fade block with its register port
// depends on qfo_pkg, qfo_front, qfo_queue and qfo_back

// Closing fade for a stream of stereo frames. Each frame pushed in counts down the
// frames left in the song (restart reloads the count from total_frames first); a
// frame that finds the count at zero is dropped and gives no word at the result
// side. While n frames remain and n <= fade_frames, both samples are scaled by
// g = floor(floor(n*65536/fade_frames)^2 / 65536), with 65536 as unity; fade_frames
// of zero turns fading off. The front takes a frame per cycle while its command
// queue has room; the back handles one frame at a time: it takes each from the queue,
// runs a faded frame through the bit-serial divider (one quotient bit per cycle),
// square and scale and a unity-gain frame through scale alone, and loads the result
// register once it is free. Registers sit at byte address 0 (total_frames) and 4
// (fade_frames); the user writes them only while the block is idle (not enforced).

module quadratic_fade_out_top #(
    parameter int unsigned QUEUE_DEPTH = qfo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // frame side
    input  qfo_pkg::frame_t                 frame,
    input  logic                            push,
    output logic                            full,
    // result side
    output qfo_pkg::result_t                result,
    output logic                            empty,
    input  logic                            pop,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qfo_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [qfo_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [qfo_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import qfo_pkg::*;

    logic [COUNT_W-1:0] total_frames_reg;
    logic [COUNT_W-1:0] fade_frames_reg;
    logic               cfg_write;

    // front to queue, queue to back
    logic               q_push;
    logic               q_full;
    cmd_t               q_wdata;
    logic               q_pop;
    logic               q_empty;
    cmd_t               q_rdata;

    // register port, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= '0;
            fade_frames_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                CFG_TOTAL: total_frames_reg <= pwdata;
                CFG_FADE:  fade_frames_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    // read back, address bits below the word are ignored
    always_comb
    begin
        unique case (paddr[2])
            CFG_TOTAL: prdata = total_frames_reg;
            CFG_FADE:  prdata = fade_frames_reg;
            default:   prdata = '0;
        endcase
    end

    // counts frames and decides fade or unity
    qfo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .push         (push),
        .full         (full),
        .total_frames (total_frames_reg),
        .fade_frames  (fade_frames_reg),
        .q_push       (q_push),
        .q_cmd        (q_wdata),
        .q_full       (q_full)
    );

    // lets the front run ahead of the back
    qfo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // divider, square and scaling, ends in the result register
    qfo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .cmd         (q_rdata),
        .fade_frames (fade_frames_reg),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule

### hw/rtl/qfo_front.sv
// qfo_front: accepts frames, keeps the remaining frame count and classifies each frame
// depends on qfo_pkg

module qfo_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qfo_pkg::frame_t              frame,
    input  logic                         push,
    output logic                         full,
    input  logic [qfo_pkg::COUNT_W-1:0]  total_frames,
    input  logic [qfo_pkg::COUNT_W-1:0]  fade_frames,
    output logic                         q_push,
    output qfo_pkg::cmd_t                q_cmd,
    input  logic                         q_full
);
    import qfo_pkg::*;

    logic [COUNT_W-1:0] frames_left_reg;
    logic [COUNT_W-1:0] frames_left_next;
    logic [COUNT_W-1:0] n_eff;
    logic               accept;
    logic               live;

    assign full   = q_full;
    assign accept = push && !q_full;

    // reload happens before the frame is looked at
    assign n_eff  = frame.restart ? total_frames : frames_left_reg;
    assign live   = (n_eff != '0);
    assign q_push = accept && live;

    always_comb
    begin
        q_cmd.left     = frame.left_sample;
        q_cmd.right    = frame.right_sample;
        q_cmd.frames   = n_eff;
        q_cmd.fade     = (fade_frames != '0) && (n_eff <= fade_frames);
        q_cmd.song_end = (n_eff == COUNT_W'(1));
    end

    always_comb
    begin
        frames_left_next = frames_left_reg;
        if (accept)
        begin
            frames_left_next = live ? (n_eff - COUNT_W'(1)) : n_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_left_reg <= '0;
        end
        else
        begin
            frames_left_reg <= frames_left_next;
        end
    end

endmodule

### hw/rtl/qfo_queue.sv
// qfo_queue: short command queue that decouples the front from the back
// depends on qfo_pkg; DEPTH must be 2 or more

module qfo_queue #(
    parameter int unsigned DEPTH = qfo_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qfo_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output qfo_pkg::cmd_t rdata,
    output logic          empty
);
    import qfo_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### hw/rtl/qfo_back.sv
// qfo_back: gain computation (serial divider, square) and sample scaling, one frame at a time
// depends on qfo_pkg; feeds the one-word result register

module qfo_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  qfo_pkg::cmd_t                cmd,
    input  logic [qfo_pkg::COUNT_W-1:0]  fade_frames,
    input  logic                         pop,
    output logic                         empty,
    output qfo_pkg::result_t             result
);
    import qfo_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t                       cmd_reg;
    logic [COUNT_W:0]           rem_reg;
    logic [GAIN_W-1:0]          quot_reg;
    logic [DIV_CNT_W-1:0]       cnt_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [33:0]         prod_l_reg;
    logic signed [33:0]         prod_r_reg;
    result_t                    result_reg;
    logic                       out_valid_reg;

    logic                       q_bit;
    logic [COUNT_W:0]           rem_sub;
    logic [COUNT_W-1:0]         rem_keep;
    logic [2*GAIN_W-1:0]        square;
    logic                       out_free;
    logic                       out_load;

    // one quotient bit per cycle; remainder stays below the divisor
    assign q_bit    = (rem_reg >= {1'b0, fade_frames});
    assign rem_sub  = rem_reg - {1'b0, fade_frames};
    assign rem_keep = q_bit ? rem_sub[COUNT_W-1:0] : rem_reg[COUNT_W-1:0];
    assign square   = quot_reg * quot_reg;

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = result_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = cmd.fade ? BK_DIV : BK_SCALE;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg  <= cmd;
            rem_reg  <= {1'b0, cmd.frames};
            quot_reg <= '0;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            gain_reg <= UNITY_GAIN;
        end
        if (state_reg == BK_DIV)
        begin
            rem_reg  <= {rem_keep, 1'b0};
            quot_reg <= {quot_reg[GAIN_W-2:0], q_bit};
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
        end
        if (state_reg == BK_SQUARE)
        begin
            gain_reg <= square[GAIN_W+15:16];
        end
        if (state_reg == BK_SCALE)
        begin
            prod_l_reg <= 34'(cmd_reg.left * $signed({1'b0, gain_reg}));
            prod_r_reg <= 34'(cmd_reg.right * $signed({1'b0, gain_reg}));
        end
        if (out_load)
        begin
            result_reg.left_out     <= prod_l_reg[31:16];
            result_reg.right_out    <= prod_r_reg[31:16];
            result_reg.gain_applied <= gain_reg;
            result_reg.song_end     <= cmd_reg.song_end;
        end
    end

endmodule
